>>> src/bell_function_sum_evaluator_core_macros.svh
// Assertion macros for the bell-function sum evaluator.
// Included by the RTL files that carry concurrent assertions.
`ifndef BELL_FUNCTION_SUM_EVALUATOR_CORE_MACROS_SVH
`define BELL_FUNCTION_SUM_EVALUATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BFSE_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bfse assertion failed");

// Next-cycle implication, disabled during reset.
`define BFSE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bfse assertion failed");

`endif

>>> src/bfse_pkg.sv
// Shared types, constants and helpers for the bell-function sum evaluator.
// No dependencies; used by the interfaces, the core, the divider and the multiplier.
`default_nettype none
package bfse_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_CONFIDENCE  = 15;
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int CONF_W          = 4;
  localparam int VAL_W           = 32;
  localparam int IDX_W           = 4;
  localparam int OP_W            = 3;
  localparam int SEL_W           = 2;
  localparam int STS_W           = 2;
  localparam int USED_W          = 5;
  localparam int SUM_W           = 36;
  localparam int ACC_W           = 41;   // holds 256 gates of up to 2^31
  localparam int DIVD_W          = 33 + FRAC_BITS;
  localparam int PW              = 63;
  localparam int PROD_W          = 2 * PW;
  localparam int IPW             = VAL_W - FRAC_BITS;

  localparam logic [PW-1:0] PCAP   = PW'(1) << 62;
  localparam logic [PW-1:0] ONE_FX = PW'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SUM_MIN = -SUM_MAX - ACC_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_EVAL    = 3'd0,
    OP_APPEND  = 3'd1,
    OP_SET_AT  = 3'd2,
    OP_SET_ALL = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [SEL_W-1:0] {
    FLD_MIDDLE     = 2'd0,
    FLD_LENGTH     = 2'd1,
    FLD_AMPLITUDE  = 2'd2,
    FLD_CONFIDENCE = 2'd3
  } field_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EV_RD, S_EV_LD, S_D1_GO, S_D1_WAIT, S_SQ_GO, S_SQ_WAIT,
    S_POW_GO, S_POW_WAIT, S_D2_GO, S_D2_WAIT, S_ACC, S_SETALL,
    S_RM_RD, S_RM_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [PW-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic          start;
    logic [PW-1:0] a;
    logic [PW-1:0] b;
  } mul_req_t;

  function automatic logic [CONF_W-1:0] clamp_conf(input logic [CONF_W-1:0] c);
    return (c > CONF_W'(MAX_CONFIDENCE)) ? CONF_W'(MAX_CONFIDENCE) : c;
  endfunction

  // Integer part of a Q value, zero if not positive, clamped.
  function automatic logic [CONF_W-1:0] conf_from_value(input logic signed [VAL_W-1:0] v);
    logic [IPW-1:0] ip;
    ip = v[VAL_W-1:FRAC_BITS];
    if (v <= 0) return '0;
    else if (ip > IPW'(MAX_CONFIDENCE)) return CONF_W'(MAX_CONFIDENCE);
    else return CONF_W'(ip);
  endfunction

endpackage
`default_nettype wire

>>> src/bfse_if.sv
// Valid/ready channel interfaces for items and results.
// Depends on bfse_pkg for field widths.
`default_nettype none
interface bfse_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [bfse_pkg::OP_W-1:0]            operation;
  logic [bfse_pkg::IDX_W-1:0]           entry_index;
  logic [bfse_pkg::SEL_W-1:0]           field_select;
  logic signed [bfse_pkg::VAL_W-1:0]    set_value;
  logic signed [bfse_pkg::VAL_W-1:0]    middle_in;
  logic signed [bfse_pkg::VAL_W-1:0]    length_in;
  logic signed [bfse_pkg::VAL_W-1:0]    amplitude_in;
  logic [bfse_pkg::CONF_W-1:0]          confidence_in;
  logic signed [bfse_pkg::VAL_W-1:0]    sample;

  modport source (output valid, operation, entry_index, field_select, set_value,
                  middle_in, length_in, amplitude_in, confidence_in, sample,
                  input ready);
  modport sink (input valid, operation, entry_index, field_select, set_value,
                middle_in, length_in, amplitude_in, confidence_in, sample,
                output ready);
endinterface

interface bfse_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bfse_pkg::SUM_W-1:0] sum_out;
  logic [bfse_pkg::STS_W-1:0]        status;
  logic [bfse_pkg::USED_W-1:0]       entries_used;

  modport source (output valid, sum_out, status, entries_used, input ready);
  modport sink (input valid, sum_out, status, entries_used, output ready);
endinterface
`default_nettype wire

>>> src/bell_function_sum_evaluator_core.sv
// Evaluate walks the entries in use: per entry, |sample - middle| / |length| on the
// shared 49-step divider, its square and c further products (c = its confidence) on the
// 5-step multiplier, then |amplitude| / (power + 1) on the divider again; zero confidence
// needs only that second division, and otherwise a zero length adds nothing. Set in all
// entries and remove step through the table. One item at a time; a result waits in the
// output register. Synchronous reset empties the table and drops any pending result.
`default_nettype none
`include "bell_function_sum_evaluator_core_macros.svh"
module bell_function_sum_evaluator_core #(
  parameter int MAX_ENTRIES = bfse_pkg::DEF_MAX_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  bfse_in_if.sink    in_ch,
  bfse_out_if.source out_ch
);
  import bfse_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > IDX_W) ? CW + 1 : IDX_W + 1;

  // entry table
  logic signed [VAL_W-1:0] mid_mem [MAX_ENTRIES];
  logic signed [VAL_W-1:0] len_mem [MAX_ENTRIES];
  logic signed [VAL_W-1:0] amp_mem [MAX_ENTRIES];
  logic [CONF_W-1:0]       conf_mem [MAX_ENTRIES];

  state_t state, state_next;

  logic [CW-1:0]           cnt, k;
  logic [SEL_W-1:0]        sel_r;
  logic signed [VAL_W-1:0] val_r, x_r;
  logic [STS_W-1:0]        sts_r;

  logic signed [VAL_W-1:0] rd_mid, rd_len, rd_amp;
  logic [CONF_W-1:0]       rd_conf;
  logic [IW-1:0]           rd_addr, wr_addr;
  logic                    we_mid, we_len, we_amp, we_conf;
  logic signed [VAL_W-1:0] wd_mid, wd_len, wd_amp;
  logic [CONF_W-1:0]       wd_conf;

  logic [32:0]             ad_r;
  logic [VAL_W-1:0]        al_r, aa_r;
  logic                    aneg_r;
  logic [CONF_W-1:0]       conf_r, pw_cnt;
  logic [PW-1:0]           t_r, s_r, p_r;
  logic signed [32:0]      gate_r;
  logic signed [ACC_W-1:0] sum_acc;

  logic                    out_valid;
  logic signed [SUM_W-1:0] sum_q, sum_sat;
  logic [STS_W-1:0]        sts_q;
  logic [USED_W-1:0]       used_q;

  div_req_t                div_req;
  mul_req_t                mul_req;
  logic                    div_busy, div_done, mul_busy, mul_done;
  logic [DIVD_W-1:0]       quot;
  logic [PW-1:0]           mres;

  logic                    accept, idx_ok, tbl_full, load_out;
  logic signed [32:0]      dlt;
  logic [32:0]             ad;
  logic [VAL_W-1:0]        al, aa;
  logic [CW:0]             k_inc;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign idx_ok    = (XW'(in_ch.entry_index) < XW'(cnt)) &&
                     (XW'(in_ch.entry_index) < XW'(MAX_ENTRIES));
  assign tbl_full  = (XW'(cnt) >= XW'(MAX_ENTRIES));
  assign k_inc     = (CW+1)'(k) + (CW+1)'(1);
  assign load_out  = (state == S_DONE) && (!out_valid || out_ch.ready);

  assign dlt = 33'(x_r) - 33'(rd_mid);
  assign ad  = dlt[32] ? 33'(-dlt) : 33'(dlt);
  assign al  = rd_len[VAL_W-1] ? VAL_W'(-rd_len) : VAL_W'(rd_len);
  assign aa  = rd_amp[VAL_W-1] ? VAL_W'(-rd_amp) : VAL_W'(rd_amp);

  always_comb begin
    if (sum_acc > SUM_MAX)      sum_sat = SUM_W'(SUM_MAX);
    else if (sum_acc < SUM_MIN) sum_sat = SUM_W'(SUM_MIN);
    else                        sum_sat = SUM_W'(sum_acc);
  end

  bfse_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quot (quot)
  );

  bfse_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .busy (mul_busy),
    .done (mul_done),
    .res  (mres)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.operation)
            OP_EVAL:    state_next = (cnt == '0) ? S_DONE : S_EV_RD;
            OP_SET_ALL: state_next = S_SETALL;
            OP_REMOVE:  state_next = idx_ok ? S_RM_RD : S_DONE;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_EV_RD: state_next = S_EV_LD;
      S_EV_LD: begin
        if (rd_conf == '0)      state_next = S_D2_GO;
        else if (rd_len == '0)  state_next = S_ACC;
        else                    state_next = S_D1_GO;
      end
      S_D1_GO:    state_next = S_D1_WAIT;
      S_D1_WAIT:  if (div_done) state_next = S_SQ_GO;
      S_SQ_GO:    state_next = S_SQ_WAIT;
      S_SQ_WAIT:  if (mul_done) state_next = S_POW_GO;
      S_POW_GO:   state_next = S_POW_WAIT;
      S_POW_WAIT: begin
        if (mul_done)
          state_next = (CONF_W'(pw_cnt + 1'b1) == conf_r) ? S_D2_GO : S_POW_GO;
      end
      S_D2_GO:    state_next = S_D2_WAIT;
      S_D2_WAIT:  if (div_done) state_next = S_ACC;
      S_ACC:      state_next = (k_inc == (CW+1)'(cnt)) ? S_DONE : S_EV_RD;
      S_SETALL:   if (k >= cnt) state_next = S_DONE;
      S_RM_RD:    state_next = (k_inc < (CW+1)'(cnt)) ? S_RM_WR : S_DONE;
      S_RM_WR:    state_next = S_RM_RD;
      S_DONE:     if (!out_valid || out_ch.ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // unit requests, table writes and read address
  always_comb begin
    div_req = '0;
    mul_req = '0;
    we_mid  = 1'b0;
    we_len  = 1'b0;
    we_amp  = 1'b0;
    we_conf = 1'b0;
    wr_addr = IW'(k);
    wd_mid  = val_r;
    wd_len  = val_r;
    wd_amp  = val_r;
    wd_conf = conf_from_value(val_r);
    rd_addr = (state == S_RM_RD) ? IW'(k_inc) : IW'(k);
    unique case (state)
      S_IDLE: begin
        if (accept && in_ch.operation == OP_APPEND && !tbl_full) begin
          wr_addr = IW'(cnt);
          {we_mid, we_len, we_amp, we_conf} = 4'b1111;
          wd_mid  = in_ch.middle_in;
          wd_len  = in_ch.length_in;
          wd_amp  = in_ch.amplitude_in;
          wd_conf = clamp_conf(in_ch.confidence_in);
        end else if (accept && in_ch.operation == OP_SET_AT && idx_ok) begin
          wr_addr = IW'(in_ch.entry_index);
          wd_mid  = in_ch.set_value;
          wd_len  = in_ch.set_value;
          wd_amp  = in_ch.set_value;
          wd_conf = conf_from_value(in_ch.set_value);
          unique case (in_ch.field_select)
            FLD_MIDDLE:    we_mid  = 1'b1;
            FLD_LENGTH:    we_len  = 1'b1;
            FLD_AMPLITUDE: we_amp  = 1'b1;
            default:       we_conf = 1'b1;
          endcase
        end
      end
      S_SETALL: begin
        if (k < cnt) begin
          unique case (sel_r)
            FLD_MIDDLE:    we_mid  = 1'b1;
            FLD_LENGTH:    we_len  = 1'b1;
            FLD_AMPLITUDE: we_amp  = 1'b1;
            default:       we_conf = 1'b1;
          endcase
        end
      end
      S_RM_WR: begin
        {we_mid, we_len, we_amp, we_conf} = 4'b1111;
        wd_mid  = rd_mid;
        wd_len  = rd_len;
        wd_amp  = rd_amp;
        wd_conf = rd_conf;
      end
      S_D1_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'({ad_r, FRAC_BITS'(0)});
        div_req.divisor  = PW'(al_r);
      end
      S_SQ_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = t_r;
        mul_req.b     = t_r;
      end
      S_POW_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = p_r;
        mul_req.b     = s_r;
      end
      S_D2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'({aa_r, FRAC_BITS'(0)});
        div_req.divisor  = p_r + ONE_FX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_mid)  mid_mem[wr_addr]  <= wd_mid;
    if (we_len)  len_mem[wr_addr]  <= wd_len;
    if (we_amp)  amp_mem[wr_addr]  <= wd_amp;
    if (we_conf) conf_mem[wr_addr] <= wd_conf;
    rd_mid  <= mid_mem[rd_addr];
    rd_len  <= len_mem[rd_addr];
    rd_amp  <= amp_mem[rd_addr];
    rd_conf <= conf_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_ch.operation == OP_APPEND && !tbl_full) cnt <= cnt + CW'(1);
        if (in_ch.operation == OP_CLEAR)               cnt <= '0;
      end
      if (state == S_RM_RD && !(k_inc < (CW+1)'(cnt))) cnt <= cnt - CW'(1);
      if (load_out)          out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          sel_r   <= in_ch.field_select;
          val_r   <= in_ch.set_value;
          x_r     <= in_ch.sample;
          sum_acc <= '0;
          k       <= (in_ch.operation == OP_REMOVE) ? CW'(in_ch.entry_index) : '0;
          if (in_ch.operation == OP_APPEND && tbl_full)
            sts_r <= ST_FULL;
          else if ((in_ch.operation == OP_SET_AT || in_ch.operation == OP_REMOVE) && !idx_ok)
            sts_r <= ST_BAD_INDEX;
          else
            sts_r <= ST_OK;
        end
      end
      S_EV_LD: begin
        ad_r   <= ad;
        al_r   <= al;
        aa_r   <= aa;
        aneg_r <= rd_amp[VAL_W-1];
        conf_r <= rd_conf;
        p_r    <= ONE_FX;
        gate_r <= '0;
      end
      S_D1_WAIT:  if (div_done) t_r <= PW'(quot);
      S_SQ_WAIT: begin
        if (mul_done) begin
          s_r    <= mres;
          pw_cnt <= '0;
        end
      end
      S_POW_WAIT: begin
        if (mul_done) begin
          p_r    <= mres;
          pw_cnt <= pw_cnt + 1'b1;
        end
      end
      S_D2_WAIT: begin
        if (div_done)
          gate_r <= aneg_r ? -$signed({1'b0, quot[31:0]}) : $signed({1'b0, quot[31:0]});
      end
      S_ACC: begin
        sum_acc <= sum_acc + ACC_W'(gate_r);
        k       <= k + CW'(1);
      end
      S_SETALL: if (k < cnt) k <= k + CW'(1);
      S_RM_WR:  k <= k + CW'(1);
      S_DONE: begin
        if (load_out) begin
          sum_q  <= sum_sat;
          sts_q  <= sts_r;
          used_q <= USED_W'(cnt);
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sum_out      = sum_q;
  assign out_ch.status       = sts_q;
  assign out_ch.entries_used = used_q;

  `BFSE_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(MAX_ENTRIES))
  `BFSE_ASSERT_IMPL(a_idle_units_free, clk, rst, state == S_IDLE, !div_busy && !mul_busy)
  `BFSE_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_ch.valid && in_ch.ready, state != S_IDLE)
  `BFSE_ASSERT_IMPL(a_mul_done_ctx, clk, rst, mul_done, state == S_SQ_WAIT || state == S_POW_WAIT)

endmodule
`default_nettype wire

>>> src/bfse_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bfse_pkg.
`default_nettype none
module bfse_div (
  input  logic                        clk,
  input  logic                        rst,
  input  bfse_pkg::div_req_t          req,
  output logic                        busy,
  output logic                        done,
  output logic [bfse_pkg::DIVD_W-1:0] quot
);
  import bfse_pkg::*;

  localparam int SW = $clog2(DIVD_W + 1);

  logic [PW-1:0]     rem;
  logic [DIVD_W-1:0] q;
  logic [PW-1:0]     dvs;
  logic [SW-1:0]     steps;
  logic [PW:0]       trial;
  logic [PW+1:0]     diff;

  assign trial = {rem, q[DIVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, dvs};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps == SW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q     <= req.dividend;
      dvs   <= req.divisor;
      rem   <= '0;
      steps <= SW'(DIVD_W);
    end else if (busy) begin
      if (!diff[PW+1]) begin
        rem <= diff[PW-1:0];
        q   <= {q[DIVD_W-2:0], 1'b1};
      end else begin
        rem <= trial[PW-1:0];
        q   <= {q[DIVD_W-2:0], 1'b0};
      end
      steps <= steps - SW'(1);
    end
  end

endmodule
`default_nettype wire

>>> src/bfse_mul.sv
// Fixed-point multiplier: four 32x32 partial products, result shifted down by the
// fraction and saturated.  Depends on bfse_pkg.
`default_nettype none
module bfse_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  bfse_pkg::mul_req_t      req,
  output logic                    busy,
  output logic                    done,
  output logic [bfse_pkg::PW-1:0] res
);
  import bfse_pkg::*;

  logic [PW-1:0]     a, b;
  logic [2:0]        step;
  logic [63:0]       pp, prod;
  logic [1:0]        psh;
  logic [PROD_W-1:0] acc, ppx;
  logic [31:0]       opa, opb;

  // step 0: a0*b0, 1: a1*b0, 2: a0*b1, 3: a1*b1
  assign opa  = step[0] ? {1'b0, a[PW-1:32]} : a[31:0];
  assign opb  = step[1] ? {1'b0, b[PW-1:32]} : b[31:0];
  assign prod = 64'(opa) * 64'(opb);

  always_comb begin
    unique case (psh)
      2'd0:    ppx = PROD_W'(pp);
      2'd1:    ppx = PROD_W'(pp) << 32;
      default: ppx = PROD_W'(pp) << 64;
    endcase
  end

  assign res = (acc[PROD_W-1:62+FRAC_BITS] != '0) ? PCAP
             : PW'(acc[62+FRAC_BITS-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == 3'd4) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a    <= req.a;
      b    <= req.b;
      step <= '0;
      acc  <= '0;
    end else if (busy) begin
      if (step <= 3'd3) begin
        pp  <= prod;
        psh <= 2'(step[0]) + 2'(step[1]);
      end
      if (step != 3'd0) acc <= acc + ppx;
      step <= step + 3'd1;
    end
  end

endmodule
`default_nettype wire

>>> test/bell_function_sum_evaluator_core_tb.sv
// Self-checking testbench for bell_function_sum_evaluator_core: directed and random
// table operations and evaluations checked against an in-bench bell-sum predictor.
// Depends on bfse_pkg, bfse_in_if/bfse_out_if and the core RTL.
`default_nettype none
module bell_function_sum_evaluator_core_tb;
  import bfse_pkg::*;

  typedef struct {
    op_t                 operation;
    logic [IDX_W-1:0]    entry_index;
    field_t              field_select;
    logic signed [31:0]  set_value;
    logic signed [31:0]  middle_in;
    logic signed [31:0]  length_in;
    logic signed [31:0]  amplitude_in;
    logic [CONF_W-1:0]   confidence_in;
    logic signed [31:0]  sample;
  } bell_item_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum_out;
    logic [STS_W-1:0]        status;
    logic [USED_W-1:0]       entries_used;
  } bell_result_t;

  localparam int TABLE_DEPTH = 16;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 2000;

  logic clk = 0;
  logic rst = 1;
  bfse_in_if  in_ch();
  bfse_out_if out_ch();

  bell_function_sum_evaluator_core DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  bell_item_t   pending_items[$];
  bell_result_t expected_sums[$];
  int errors = 0;
  longint cycle_count = 0;
  bit hold_off = 0;
  int hold_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit in_ch_accepted = 0;

  // predictor copy of the table
  logic signed [31:0] p_mid[TABLE_DEPTH];
  logic signed [31:0] p_len[TABLE_DEPTH];
  logic signed [31:0] p_amp[TABLE_DEPTH];
  logic [CONF_W-1:0]  p_conf[TABLE_DEPTH];
  int                 p_count = 0;

  localparam logic [63:0] CAP = 64'd1 << 62;

  function automatic logic [63:0] fx_mul_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = (128'(a) * 128'(b)) >> FRAC_BITS;
    return (prod > 128'(CAP)) ? CAP : prod[63:0];
  endfunction

  function automatic logic signed [63:0] bell_gate(int k, logic signed [31:0] x);
    logic signed [63:0] d, amp, len;
    logic [63:0] ad, al, t, s, p, mag;
    amp = p_amp[k];
    len = p_len[k];
    d = 64'(x) - 64'(p_mid[k]);
    p = 64'd1 << FRAC_BITS;
    if (p_conf[k] != 0) begin
      if (len == 0) return 0;
      ad = d < 0 ? -d : d;
      al = len < 0 ? -len : len;
      t = (ad << FRAC_BITS) / al;
      if (t > CAP) t = CAP;
      s = fx_mul_sat(t, t);
      for (int i = 0; i < p_conf[k]; i++) p = fx_mul_sat(p, s);
    end
    mag = ((amp < 0 ? -amp : amp) << FRAC_BITS) / (p + (64'd1 << FRAC_BITS));
    return amp < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [CONF_W-1:0] conf_of_value(logic signed [31:0] v);
    if (v <= 0) return 0;
    if ((v >>> FRAC_BITS) > MAX_CONFIDENCE) return MAX_CONFIDENCE;
    return CONF_W'(v >>> FRAC_BITS);
  endfunction

  task automatic write_field(int k, field_t sel, logic signed [31:0] v);
    case (sel)
      FLD_MIDDLE:    p_mid[k] = v;
      FLD_LENGTH:    p_len[k] = v;
      FLD_AMPLITUDE: p_amp[k] = v;
      default:       p_conf[k] = conf_of_value(v);
    endcase
  endtask

  task automatic predict_bell_sum(bell_item_t it);
    bell_result_t r;
    logic signed [63:0] acc;
    acc = 0;
    r.status = ST_OK;
    case (it.operation)
      OP_EVAL: begin
        for (int k = 0; k < p_count; k++) acc += bell_gate(k, it.sample);
        if (acc > 64'sd34359738367) acc = 64'sd34359738367;
        if (acc < -64'sd34359738368) acc = -64'sd34359738368;
      end
      OP_APPEND: begin
        if (p_count >= TABLE_DEPTH) r.status = ST_FULL;
        else begin
          p_mid[p_count] = it.middle_in;
          p_len[p_count] = it.length_in;
          p_amp[p_count] = it.amplitude_in;
          p_conf[p_count] = it.confidence_in > MAX_CONFIDENCE ? CONF_W'(MAX_CONFIDENCE)
                                                              : it.confidence_in;
          p_count++;
        end
      end
      OP_SET_AT: begin
        if (it.entry_index >= p_count) r.status = ST_BAD_INDEX;
        else write_field(it.entry_index, it.field_select, it.set_value);
      end
      OP_SET_ALL: for (int k = 0; k < p_count; k++) write_field(k, it.field_select, it.set_value);
      OP_REMOVE: begin
        if (it.entry_index >= p_count) r.status = ST_BAD_INDEX;
        else begin
          for (int k = it.entry_index; k + 1 < p_count; k++) begin
            p_mid[k] = p_mid[k+1];
            p_len[k] = p_len[k+1];
            p_amp[k] = p_amp[k+1];
            p_conf[k] = p_conf[k+1];
          end
          p_count--;
        end
      end
      OP_CLEAR: p_count = 0;
      default: ;
    endcase
    r.sum_out = acc[SUM_W-1:0];
    r.entries_used = USED_W'(p_count);
    expected_sums = {expected_sums, r};
  endtask

  task automatic queue_item(bell_item_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic bell_item_t make_item(op_t op);
    bell_item_t it;
    it.operation = op;
    it.entry_index = IDX_W'($urandom_range(0, 15));
    it.field_select = field_t'($urandom_range(0, 3));
    it.set_value = rand_val();
    if (it.field_select == FLD_CONFIDENCE && $urandom_range(0, 1))
      it.set_value = $signed($urandom_range(0, 20 << 16)) - 32'sh00020000;
    it.middle_in = rand_val();
    it.length_in = $urandom_range(0, 7) == 0 ? 32'sd0 : rand_val();
    it.amplitude_in = rand_val();
    it.confidence_in = $urandom_range(0, 3) == 0 ? CONF_W'($urandom_range(0, 15))
                                                 : CONF_W'($urandom_range(0, 3));
    it.sample = rand_val();
    return it;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bell_function_sum_evaluator_core regression: fail");
      $finish;
    end
  end

  // driver: bursts and gaps, changes at the falling edge
  initial begin
    in_ch.valid = 0;
    in_ch.operation = OP_EVAL;
    in_ch.entry_index = 0;
    in_ch.field_select = FLD_MIDDLE;
    in_ch.set_value = 0;
    in_ch.middle_in = 0;
    in_ch.length_in = 0;
    in_ch.amplitude_in = 0;
    in_ch.confidence_in = 0;
    in_ch.sample = 0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch_accepted) begin
        // transfer happened at the last rising edge
      end
      if (!in_ch.valid || in_ch_accepted) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          bell_item_t it;
          it = pending_items.pop_front();
          in_ch.operation <= it.operation;
          in_ch.entry_index <= it.entry_index;
          in_ch.field_select <= it.field_select;
          in_ch.set_value <= it.set_value;
          in_ch.middle_in <= it.middle_in;
          in_ch.length_in <= it.length_in;
          in_ch.amplitude_in <= it.amplitude_in;
          in_ch.confidence_in <= it.confidence_in;
          in_ch.sample <= it.sample;
          in_ch.valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 6);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 400);
          end
        end else in_ch.valid <= 1'b0;
      end
    end
  end

  // input monitor: predict on every accepted transfer
  always @(posedge clk) begin
    in_ch_accepted <= in_ch.valid && in_ch.ready && !rst;
    if (!rst && in_ch.valid && in_ch.ready) begin
      bell_item_t it;
      it.operation = op_t'(in_ch.operation);
      it.entry_index = in_ch.entry_index;
      it.field_select = field_t'(in_ch.field_select);
      it.set_value = in_ch.set_value;
      it.middle_in = in_ch.middle_in;
      it.length_in = in_ch.length_in;
      it.amplitude_in = in_ch.amplitude_in;
      it.confidence_in = in_ch.confidence_in;
      it.sample = in_ch.sample;
      predict_bell_sum(it);
    end
  end

  // receiver stall pattern; a long hold-off is counted here
  int stall_left = 0;
  initial out_ch.ready = 0;
  always @(negedge clk) begin
    if (hold_off) begin
      out_ch.ready <= 1'b0;
      if (hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
    end else begin
      hold_count <= 0;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        stall_left <= $urandom_range(1, 300);
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result sum_out=%0d status=%0d", out_ch.sum_out, out_ch.status);
        errors++;
      end else begin
        bell_result_t e;
        e = expected_sums.pop_front();
        if (out_ch.sum_out !== e.sum_out) begin
          $error("sum_out expected %0d actual %0d", e.sum_out, out_ch.sum_out);
          errors++;
        end
        if (out_ch.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_ch.status);
          errors++;
        end
        if (out_ch.entries_used !== e.entries_used) begin
          $error("entries_used expected %0d actual %0d", e.entries_used, out_ch.entries_used);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || expected_sums.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    bell_item_t it;
    int used;
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: empty-table errors, extremes, zero length, clamping, full table
    queue_item(make_item(OP_EVAL));
    it = make_item(OP_REMOVE); it.entry_index = 0; queue_item(it);
    it = make_item(OP_SET_AT); it.entry_index = 15; queue_item(it);
    it = make_item(OP_SET_ALL); queue_item(it);
    it = make_item(OP_APPEND); it.middle_in = 32'sh80000000; it.length_in = 0;
    it.amplitude_in = 32'sh7fffffff; it.confidence_in = 15; queue_item(it);
    it = make_item(OP_APPEND); it.middle_in = 32'sh7fffffff; it.length_in = 0;
    it.amplitude_in = 32'sh80000000; it.confidence_in = 0; queue_item(it);
    it = make_item(OP_APPEND); it.middle_in = 0; it.length_in = 32'sh80000000;
    it.amplitude_in = 32'sh00010000; it.confidence_in = 4'hf; queue_item(it);
    it = make_item(OP_EVAL); it.sample = 32'sh7fffffff; queue_item(it);
    it = make_item(OP_EVAL); it.sample = 32'sh80000000; queue_item(it);
    it = make_item(OP_SET_AT); it.entry_index = 2; it.field_select = FLD_CONFIDENCE;
    it.set_value = 32'sh7fffffff; queue_item(it);
    it = make_item(OP_SET_ALL); it.field_select = FLD_CONFIDENCE;
    it.set_value = 32'sh80000000; queue_item(it);
    it = make_item(OP_SET_AT); it.entry_index = 3; queue_item(it);
    for (int i = 0; i < 14; i++) begin
      it = make_item(OP_APPEND); it.amplitude_in = 32'sh7fffffff; queue_item(it);
    end
    it = make_item(OP_EVAL); it.sample = 0; queue_item(it);
    it = make_item(OP_REMOVE); it.entry_index = 15; queue_item(it);
    it = make_item(OP_REMOVE); it.entry_index = 0; queue_item(it);
    queue_item(make_item(OP_CLEAR));
    wait_drained();

    // hold the receiver off while items keep coming
    hold_off = 1;
    for (int i = 0; i < 6; i++) queue_item(make_item(OP_APPEND));
    queue_item(make_item(OP_EVAL));
    wait (hold_count == HOLD_CYCLES);
    hold_off = 0;
    wait_drained();

    // random: mostly builds up and evaluates a small table
    used = 6;
    for (int n = 0; n < 330; n++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) it = make_item(OP_EVAL);
      else if (r < 55) it = make_item(OP_APPEND);
      else if (r < 70) it = make_item(OP_SET_AT);
      else if (r < 78) it = make_item(OP_SET_ALL);
      else if (r < 93) it = make_item(OP_REMOVE);
      else it = make_item(OP_CLEAR);
      if (it.operation inside {OP_SET_AT, OP_REMOVE} && $urandom_range(0, 3) != 0)
        it.entry_index = IDX_W'($urandom_range(0, used > 0 ? used - 1 : 0));
      case (it.operation)
        OP_APPEND: if (used < 16) used++;
        OP_REMOVE: if (it.entry_index < used) used--;
        OP_CLEAR:  used = 0;
        default: ;
      endcase
      queue_item(it);
      // sender waits until every result so far has come back
      if (n == 150) wait_drained();
    end
    wait_drained();
    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_sums.size() == 0)
      $display("bell_function_sum_evaluator_core regression: pass");
    else
      $display("bell_function_sum_evaluator_core regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+src
src/bfse_pkg.sv
src/bfse_if.sv
src/bfse_div.sv
src/bfse_mul.sv
src/bell_function_sum_evaluator_core.sv
test/bell_function_sum_evaluator_core_tb.sv
